/* hdl/stepper_trapezoid_ramp_unit_macros.svh */
// Assertion macros for the stepper ramp unit.
// Included by the top level; empty bodies when SYNTHESIS is defined.
`ifndef STEPPER_TRAPEZOID_RAMP_UNIT_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define STR_ASSERT_CLK(lbl, clk_i, rstn_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
    else $error("stepper ramp assertion failed");
`define STR_ASSERT(lbl, prop) `STR_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define STR_ASSERT_CLK(lbl, clk_i, rstn_i, prop)
`define STR_ASSERT(lbl, prop)
`endif

`endif

/* hdl/str_pkg.sv */
// Shared types, constants and reset values for the stepper ramp unit.
// No dependencies.
package str_pkg;

  localparam int PERIOD_FRAC_BITS = 12;
  localparam int ACCEL_FRAC_BITS  = 48;

  localparam int PERIOD_W = 32;
  localparam int POS_W    = 32;
  localparam int DIST_W   = 31;
  localparam int ACCEL_W  = 48;
  localparam int LIMB_BITS   = 32;
  localparam int LIMBS       = 5;
  localparam int PROD_W      = LIMBS * LIMB_BITS;
  localparam int MUL_PASSES  = 3;
  localparam int CUBE_SHIFT  = ACCEL_FRAC_BITS + 2 * PERIOD_FRAC_BITS;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ABS  = 2'd1;
  localparam logic [1:0] OP_REL  = 2'd2;

  localparam logic [1:0] REG_INITIAL_PERIOD = 2'd0;
  localparam logic [1:0] REG_CRUISE_PERIOD  = 2'd1;
  localparam logic [1:0] REG_FULL_DECEL     = 2'd2;
  localparam logic [1:0] REG_ACCEL          = 2'd3;

  localparam logic [PERIOD_W-1:0] INITIAL_PERIOD_RST = 32'd5791744;
  localparam logic [PERIOD_W-1:0] CRUISE_PERIOD_RST  = 32'd256000;
  localparam logic [DIST_W-1:0]   FULL_DECEL_RST     = 31'd512;
  localparam logic [ACCEL_W-1:0]  ACCEL_RST          = 48'd70368744;

  typedef struct packed {
    logic [PERIOD_W-1:0] initial_period;
    logic [PERIOD_W-1:0] cruise_period;
    logic [DIST_W-1:0]   full_decel_distance;
    logic [ACCEL_W-1:0]  accel_per_us2;
  } cfg_regs_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic limb_first;
    logic upd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_step;
  } dp_status_t;

endpackage

/* hdl/str_cfg_regs.sv */
// APB-style configuration register file for the stepper ramp unit.
// Depends on str_pkg.
module str_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [str_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [str_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [str_pkg::CFG_DATA_W-1:0] prdata,
  output str_pkg::cfg_regs_t             cfg
);
  import str_pkg::*;

  cfg_regs_t  cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_INITIAL_PERIOD: cfg_nxt.initial_period      = pwdata[PERIOD_W-1:0];
        REG_CRUISE_PERIOD:  cfg_nxt.cruise_period       = pwdata[PERIOD_W-1:0];
        REG_FULL_DECEL:     cfg_nxt.full_decel_distance = pwdata[DIST_W-1:0];
        REG_ACCEL:          cfg_nxt.accel_per_us2       = pwdata[ACCEL_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INITIAL_PERIOD: prdata = CFG_DATA_W'(cfg_r.initial_period);
      REG_CRUISE_PERIOD:  prdata = CFG_DATA_W'(cfg_r.cruise_period);
      REG_FULL_DECEL:     prdata = CFG_DATA_W'(cfg_r.full_decel_distance);
      REG_ACCEL:          prdata = CFG_DATA_W'(cfg_r.accel_per_us2);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_period      <= INITIAL_PERIOD_RST;
      cfg_r.cruise_period       <= CRUISE_PERIOD_RST;
      cfg_r.full_decel_distance <= FULL_DECEL_RST;
      cfg_r.accel_per_us2       <= ACCEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/str_ctrl.sv */
// Sequencing FSM for the stepper ramp unit: handshakes and multiply schedule.
// Depends on str_pkg; drives str_datapath through ctrl_cmd_t.
module str_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  str_pkg::dp_status_t status,
  output str_pkg::ctrl_cmd_t  cmd
);
  import str_pkg::*;

  localparam int LIMB_W = $clog2(LIMBS);
  localparam int PASS_W = $clog2(MUL_PASSES);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LIMB_W-1:0] limb_r, limb_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              limb_last;

  assign limb_last = (limb_r == LIMB_W'(LIMBS - 1));

  always_comb begin
    state_nxt = state_r;
    limb_nxt  = limb_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        limb_nxt = '0;
        pass_nxt = '0;
        state_nxt = status.need_step ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd.mul        = 1'b1;
        cmd.limb_first = (limb_r == '0);
        if (limb_last) begin
          limb_nxt = '0;
          pass_nxt = pass_r + 1'b1;
          if (pass_r == PASS_W'(MUL_PASSES - 1)) begin
            state_nxt = ST_UPD;
          end
        end else begin
          limb_nxt = limb_r + 1'b1;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limb_r      <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limb_r      <= limb_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/str_datapath.sv */
// Datapath of the stepper ramp unit: motion state, serial period-cube multiplier,
// period update and result register. Depends on str_pkg.
module str_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  str_pkg::cfg_regs_t         cfg,
  input  str_pkg::ctrl_cmd_t         cmd,
  output str_pkg::dp_status_t        status,
  input  logic [1:0]                 in_op,
  input  logic signed [31:0]         in_move_value,
  output logic                       out_step_pulse,
  output logic                       out_dir_negative,
  output logic                       out_done_res,
  output logic signed [31:0]         out_position_now
);
  import str_pkg::*;

  logic [1:0]          op_r;
  logic [POS_W-1:0]    mv_r;
  logic [POS_W-1:0]    position_r, position_nxt;
  logic [POS_W-1:0]    target_r, target_nxt;
  logic [PERIOD_W-1:0] next_period_r, next_period_nxt;
  logic [PERIOD_W-1:0] elapsed_r, elapsed_nxt;
  logic [DIST_W-1:0]   decel_dist_r, decel_dist_nxt;
  logic                decelerating_r, decelerating_nxt;
  logic                moving_down_r, moving_down_nxt;
  logic                step_r, step_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [LIMB_BITS-1:0] carry_r, carry_nxt;

  logic                out_step_r, out_dir_r, out_done_r;
  logic [POS_W-1:0]    out_pos_r;

  logic [POS_W-1:0]    move_target;
  logic [POS_W:0]      move_dist;
  logic [POS_W:0]      cur_dist;
  logic                at_target;
  logic [PERIOD_W-1:0] elapsed_inc;
  logic [PERIOD_W-1:0] period_int;
  logic                step_due;
  logic [63:0]         mac;
  logic [PROD_W-1:0]   prod_shifted;
  logic [PERIOD_W-1:0] cube_t;
  logic                cube_big;
  logic [PERIOD_W:0]   period_sum;
  logic [PERIOD_W-1:0] np_raw;

  function automatic logic [POS_W:0] abs_diff(input logic [POS_W-1:0] a,
                                              input logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[POS_W] ? (~d + 1'b1) : d;
  endfunction

  assign move_target = (op_r == OP_ABS) ? mv_r : position_r + mv_r;
  assign move_dist   = abs_diff(move_target, position_r);
  assign cur_dist    = abs_diff(target_r, position_r);
  assign at_target   = (position_r == target_r);
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign period_int  = next_period_r >> PERIOD_FRAC_BITS;
  assign step_due    = (op_r == OP_TICK) && !at_target && (elapsed_inc >= period_int);

  assign status.need_step = step_due;

  // one 32x32 limb per cycle; the product rotates through prod_r
  assign mac = 64'(prod_r[LIMB_BITS-1:0]) * 64'(next_period_r)
             + 64'(cmd.limb_first ? '0 : carry_r);

  assign prod_shifted = prod_r >> CUBE_SHIFT;
  assign cube_t       = prod_shifted[PERIOD_W-1:0];
  assign cube_big     = |prod_shifted[PROD_W-1:PERIOD_W];
  assign period_sum   = {1'b0, next_period_r} + {1'b0, cube_t};

  always_comb begin
    if (!decelerating_r) begin
      np_raw = (cube_big || (cube_t >= next_period_r)) ? '0 : next_period_r - cube_t;
    end else begin
      np_raw = (cube_big || period_sum[PERIOD_W]) ? '1 : period_sum[PERIOD_W-1:0];
    end
  end

  always_comb begin
    position_nxt     = position_r;
    target_nxt       = target_r;
    next_period_nxt  = next_period_r;
    elapsed_nxt      = elapsed_r;
    decel_dist_nxt   = decel_dist_r;
    decelerating_nxt = decelerating_r;
    moving_down_nxt  = moving_down_r;
    step_nxt         = step_r;
    prod_nxt         = prod_r;
    carry_nxt        = carry_r;
    if (cmd.exec) begin
      step_nxt = 1'b0;
      case (op_r)
        OP_ABS, OP_REL: begin
          target_nxt      = move_target;
          moving_down_nxt = $signed(move_target) < $signed(position_r);
          if (move_dist <= {1'b0, cfg.full_decel_distance, 1'b0}) begin
            decel_dist_nxt = move_dist[DIST_W:1];
          end else begin
            decel_dist_nxt = cfg.full_decel_distance;
          end
          next_period_nxt  = cfg.initial_period;
          decelerating_nxt = 1'b0;
          elapsed_nxt      = '0;
        end
        OP_TICK: begin
          if (!at_target) begin
            if (step_due) begin
              if (cur_dist == (POS_W + 1)'(decel_dist_r)) begin
                decelerating_nxt = !decelerating_r;
              end
              position_nxt = moving_down_r ? position_r - 1'b1 : position_r + 1'b1;
              elapsed_nxt  = '0;
              step_nxt     = 1'b1;
              prod_nxt     = PROD_W'(cfg.accel_per_us2);
            end else begin
              elapsed_nxt = elapsed_inc;
            end
          end
        end
        default: step_nxt = 1'b0;
      endcase
    end
    if (cmd.mul) begin
      prod_nxt  = {mac[LIMB_BITS-1:0], prod_r[PROD_W-1:LIMB_BITS]};
      carry_nxt = mac[63:LIMB_BITS];
    end
    if (cmd.upd) begin
      next_period_nxt = (np_raw < cfg.cruise_period) ? cfg.cruise_period : np_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r     <= '0;
      target_r       <= '0;
      next_period_r  <= INITIAL_PERIOD_RST;
      elapsed_r      <= '0;
      decel_dist_r   <= '0;
      decelerating_r <= 1'b0;
      moving_down_r  <= 1'b0;
    end else begin
      position_r     <= position_nxt;
      target_r       <= target_nxt;
      next_period_r  <= next_period_nxt;
      elapsed_r      <= elapsed_nxt;
      decel_dist_r   <= decel_dist_nxt;
      decelerating_r <= decelerating_nxt;
      moving_down_r  <= moving_down_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    prod_r  <= prod_nxt;
    carry_r <= carry_nxt;
    if (cmd.load) begin
      op_r <= in_op;
      mv_r <= in_move_value;
    end
    if (cmd.out_load) begin
      out_step_r <= step_r;
      out_dir_r  <= moving_down_r;
      out_done_r <= at_target;
      out_pos_r  <= position_r;
    end
  end

  assign out_step_pulse   = out_step_r;
  assign out_dir_negative = out_dir_r;
  assign out_done_res     = out_done_r;
  assign out_position_now = out_pos_r;

endmodule

/* hdl/stepper_trapezoid_ramp_unit.sv */
// Trapezoidal stepper ramp generator: one result per input item, whatever its op.
// A tick that issues a step also runs the period update a*p^3 as 3 passes of
// 5 limbs through a single 32x32 multiplier, then the saturating update; move
// items and ticks that issue no step skip both. One item is in flight at a
// time; a finished result sits in the output register while the next item is
// taken. Configuration registers sit at byte addresses 0, 8, 16, 24.
`include "stepper_trapezoid_ramp_unit_macros.svh"

module stepper_trapezoid_ramp_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic signed [31:0]             in_move_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_step_pulse,
  output logic                           out_dir_negative,
  output logic                           out_done_res,
  output logic signed [31:0]             out_position_now,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [str_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [str_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [str_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import str_pkg::*;

  cfg_regs_t  cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [4:0] cmd_vec;

  assign pready = 1'b1;

  str_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  str_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  str_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_op            (in_op),
    .in_move_value    (in_move_value),
    .out_step_pulse   (out_step_pulse),
    .out_dir_negative (out_dir_negative),
    .out_done_res     (out_done_res),
    .out_position_now (out_position_now)
  );

  assign cmd_vec = {cmd.load, cmd.exec, cmd.mul, cmd.upd, cmd.out_load};

  `STR_ASSERT(a_single_cmd, $onehot0(cmd_vec))
  `STR_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready)
  `STR_ASSERT(a_upd_after_mul, cmd.upd |-> $past(cmd.mul))

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for stepper_trapezoid_ramp_unit: scoreboard class with a
// bit-exact ramp predictor, APB register writes, random valid/ready traffic.
// Depends on str_pkg and the unit's RTL.
module testbench;
  import str_pkg::*;

  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int CUBE_SH = ACCEL_FRAC_BITS + 2 * PERIOD_FRAC_BITS;
  localparam logic [47:0] ACCEL_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    bit          step;
    bit          dir_neg;
    bit          done;
    logic [31:0] pos;
  } ramp_result_t;

  class ramp_scoreboard;
    logic [31:0] init_per, cruise_per;
    logic [30:0] full_decel;
    logic [47:0] accel;
    logic [31:0] pos, tgt, period, elapsed;
    logic [30:0] decel_dist;
    bit          decel, down;
    ramp_result_t expected_q[$];
    int          errors;

    function new();
      init_per   = INITIAL_PERIOD_RST;
      cruise_per = CRUISE_PERIOD_RST;
      full_decel = FULL_DECEL_RST;
      accel      = ACCEL_RST;
      pos = '0; tgt = '0; period = INITIAL_PERIOD_RST; elapsed = '0;
      decel_dist = '0; decel = 0; down = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] v);
      case (idx)
        REG_INITIAL_PERIOD: init_per = v[31:0];
        REG_CRUISE_PERIOD:  cruise_per = v[31:0];
        REG_FULL_DECEL:     full_decel = v[30:0];
        REG_ACCEL:          accel = v[47:0];
        default: ;
      endcase
    endfunction

    function bit at_target();
      return pos == tgt;
    endfunction

    function logic [32:0] span();
      logic signed [32:0] d;
      d = $signed({tgt[31], tgt}) - $signed({pos[31], pos});
      return (d < 0) ? -d : d;
    endfunction

    // a*p^3 in period units, saturated to 32 bits
    function logic [31:0] cube_term(logic [31:0] p, output bit big);
      logic [159:0] prod, sh;
      prod = {112'd0, accel};
      prod = prod * {128'd0, p};
      prod = prod * {128'd0, p};
      prod = prod * {128'd0, p};
      sh = prod >> CUBE_SH;
      big = |sh[159:32];
      return big ? 32'hFFFF_FFFF : sh[31:0];
    endfunction

    function void note_input(logic [1:0] op, logic [31:0] mv);
      ramp_result_t r;
      logic [32:0]  d, sum;
      logic [31:0]  t, np;
      bit           big, stepped;
      stepped = 0;
      if (op == OP_ABS || op == OP_REL) begin
        tgt = (op == OP_ABS) ? mv : pos + mv;
        down = $signed(tgt) < $signed(pos);
        d = span();
        if (d <= {1'b0, full_decel, 1'b0}) decel_dist = d[31:1];
        else decel_dist = full_decel;
        period = init_per;
        decel = 0;
        elapsed = '0;
      end else if (op == OP_TICK && pos != tgt) begin
        if (elapsed != 32'hFFFF_FFFF) elapsed++;
        if (elapsed >= (period >> PERIOD_FRAC_BITS)) begin
          if (span() == {2'b00, decel_dist}) decel = !decel;
          pos = down ? pos - 1 : pos + 1;
          t = cube_term(period, big);
          if (!decel) begin
            np = (big || t >= period) ? 32'd0 : period - t;
          end else begin
            sum = {1'b0, period} + {1'b0, t};
            np = (big || sum[32]) ? 32'hFFFF_FFFF : sum[31:0];
          end
          if (np < cruise_per) np = cruise_per;
          period = np;
          elapsed = '0;
          stepped = 1;
        end
      end
      r.step = stepped;
      r.dir_neg = down;
      r.done = (pos == tgt);
      r.pos = pos;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check(bit step, bit dir_neg, bit done, logic [31:0] p);
      ramp_result_t e;
      if (expected_q.size() == 0) begin
        report("result with no pending expectation");
        return;
      end
      e = expected_q.pop_front();
      if (step !== e.step) report($sformatf("step_pulse %b, want %b", step, e.step));
      if (dir_neg !== e.dir_neg)
        report($sformatf("dir_negative %b, want %b", dir_neg, e.dir_neg));
      if (done !== e.done) report($sformatf("done_res %b, want %b", done, e.done));
      if (p !== e.pos) report($sformatf("position_now %h, want %h", p, e.pos));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid, in_ready;
  logic [1:0]            in_op;
  logic [31:0]           in_move_value;
  logic                  out_valid, out_ready;
  logic                  out_step_pulse, out_dir_negative, out_done_res;
  logic [31:0]           out_position_now;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  ramp_scoreboard sb;
  int send_idle_pct, recv_stall_pct, work_items;
  bit hold_req;

  stepper_trapezoid_ramp_unit dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_op, .in_move_value,
    .out_valid, .out_ready, .out_step_pulse, .out_dir_negative, .out_done_res,
    .out_position_now,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: checks transfers, stalls at random, long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check(out_step_pulse, out_dir_negative, out_done_res, out_position_now);
      if (hold_req) begin
        hold_left = 500;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_ramp(logic [31:0] ip, logic [31:0] cp, logic [30:0] fd, logic [47:0] ac);
    cfg_write(REG_INITIAL_PERIOD, {32'd0, ip});
    cfg_write(REG_CRUISE_PERIOD, {32'd0, cp});
    cfg_write(REG_FULL_DECEL, {33'd0, fd});
    cfg_write(REG_ACCEL, {16'd0, ac});
  endtask

  task automatic send_item(logic [1:0] op, logic [31:0] mv);
    if (!(op == OP_IDLE || (op == OP_TICK && sb.at_target()))) work_items++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_move_value <= mv;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, mv);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic directed();
    send_item(OP_TICK, 32'h0000_0000);
    send_item(OP_IDLE, 32'hFFFF_FFFF);
    send_item(OP_ABS, 32'h0000_0000);
    send_item(OP_ABS, 32'h7FFF_FFFF);
    send_item(OP_TICK, 32'hFFFF_FFFF);
    send_item(OP_REL, 32'h8000_0000);
    send_item(OP_REL, 32'h0000_0000);
    drain();
    // sub-microsecond period: a step on every tick that is not at the target
    set_ramp(32'd100, 32'd40, 31'd1, ACCEL_MAX);
    send_item(OP_REL, 32'd4);
    repeat (5) send_item(OP_TICK, 32'h5555_5555);
    send_item(OP_REL, 32'h7FFF_FFFF);
    send_item(OP_TICK, 32'hAAAA_AAAA);
    send_item(OP_TICK, 32'h0000_0000);
    send_item(OP_ABS, 32'hFFFF_FFFE);
    send_item(OP_IDLE, 32'h0000_0000);
    send_item(OP_TICK, 32'h0000_0000);
    drain();
  endtask

  task automatic run_phase(int budget, int max_off, int tick_cap);
    int          start, ticks, cap;
    logic [31:0] off;
    start = work_items;
    while (work_items - start < budget) begin
      if ($urandom_range(0, 99) < 12) begin
        send_item(2'($urandom_range(0, 3)), $urandom);
      end else begin
        off = $urandom_range(0, max_off);
        if ($urandom_range(0, 1)) off = -off;
        if ($urandom_range(0, 1)) send_item(OP_ABS, sb.pos + off);
        else send_item(OP_REL, off);
        ticks = 0;
        cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : tick_cap;
        while (!sb.at_target() && ticks < cap && work_items - start < budget) begin
          send_item(OP_TICK, $urandom);
          ticks++;
        end
        if ($urandom_range(0, 3) == 0) send_item(OP_TICK, $urandom);
      end
    end
    drain();
  endtask

  initial begin
    logic [31:0] ip;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0; in_op = OP_TICK; in_move_value = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; work_items = 0; hold_req = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case (ph)
        0: set_ramp(32'd1, 32'd1, 31'd0, 48'd0);
        1: set_ramp(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, ACCEL_MAX);
        2: set_ramp(32'd1 << 19, 32'd1 << 19, 31'd1, ACCEL_MAX);
        default: begin
          ip = $urandom_range(1, 8 << PERIOD_FRAC_BITS);
          set_ramp(ip, $urandom_range(1, ip), 31'($urandom_range(0, 16)),
                   48'(({$urandom, $urandom} & {16'd0, ACCEL_MAX})
                       >> $urandom_range(4, 30)));
        end
      endcase
      if (ph == 5) hold_req = 1;
      case (ph)
        0: run_phase(120, 40, 100);
        1: run_phase(60, 40, 20);
        2: run_phase(300, 2, 400);
        default: run_phase(160, 30, 400);
      endcase
    end
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/str_pkg.sv
hdl/str_cfg_regs.sv
hdl/str_ctrl.sv
hdl/str_datapath.sv
hdl/stepper_trapezoid_ramp_unit.sv
tb/testbench.sv
